### hw/rtl/tcd_pkg.sv
// Shared types, codes and state record for the thermostat call demand core.
package tcd_pkg;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HEAT = 2'd1;
    localparam logic [1:0] KIND_COOL = 2'd2;

    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_HEAT  = 3'd1;
    localparam logic [2:0] MODE_COOL  = 3'd2;
    localparam logic [2:0] MODE_AUTO  = 3'd3;
    localparam logic [2:0] MODE_EHEAT = 3'd4;

    localparam logic [2:0] CFG_HEAT_SP = 3'd0;
    localparam logic [2:0] CFG_COOL_SP = 3'd1;
    localparam logic [2:0] CFG_HYST    = 3'd2;
    localparam logic [2:0] CFG_SUSTAIN = 3'd3;
    localparam logic [2:0] CFG_DWELL   = 3'd4;

    localparam int CFG_DATA_W = 17;

    typedef struct packed {
        logic signed [13:0] temperature;
        logic               sample_valid;
        logic [31:0]        now_seconds;
        logic               swap_allowed;
        logic [2:0]         user_mode;
    } t_in;

    typedef struct packed {
        logic [1:0]  demand_kind;
        logic        gas_only;
        logic [13:0] demand_error;
        logic        sensor_fault;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic        gas;
        logic [2:0]  prev_mode;
        logic        heat_armed;
        logic        cool_armed;
        logic [31:0] heat_since;
        logic [31:0] cool_since;
        logic        heat_ended;
        logic        cool_ended;
        logic [31:0] heat_end_t;
        logic [31:0] cool_end_t;
        logic [1:0]  last_kind;
    } t_state;

endpackage

### hw/rtl/thermostat_call_demand_core.sv
// Thermostat call demand core: hysteresis calls with auto changeover gating.
//
// One sample in, one demand result out, one transfer per cycle sustained while
// the output is not stalled. Each sample is captured in an input register and
// evaluated combinationally against the call state and the configuration on its
// way into the result register, so each result passes through the input
// register and then the result register. The result register lets the next
// sample enter while a result still waits to be taken; the input stalls only
// when both registers are full and the output is stalled.
// Write configuration only while no sample is in flight.
module thermostat_call_demand_core
    import tcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data
);

    logic signed [13:0] r_heat_sp;
    logic signed [13:0] r_cool_sp;
    logic [9:0]         r_hyst;
    logic [16:0]        r_sustain;
    logic [16:0]        r_dwell;

    logic   r_in_vld;
    t_in    r_in;
    logic   r_out_vld;
    t_out   r_out;
    t_state r_st;
    t_state n_st;
    t_out   n_out;
    logic   advance;

    logic signed [15:0] t_ext;
    logic signed [15:0] heat_sp_ext;
    logic signed [15:0] cool_sp_ext;
    logic signed [15:0] heat_on;
    logic signed [15:0] cool_on;
    logic signed [15:0] err;
    logic               heat_trig;
    logic               cool_trig;
    logic               go_auto;

    function automatic t_state f_end_call(input t_state s, input logic [31:0] now);
        t_state o;
        o = s;
        if (s.kind == KIND_HEAT) begin
            o.heat_ended = 1'b1;
            o.heat_end_t = now;
            o.last_kind  = KIND_HEAT;
        end else if (s.kind == KIND_COOL) begin
            o.cool_ended = 1'b1;
            o.cool_end_t = now;
            o.last_kind  = KIND_COOL;
        end
        o.kind = KIND_NONE;
        o.gas  = 1'b0;
        return o;
    endfunction

    function automatic logic f_elapsed_ge(input logic [31:0] now, input logic [31:0] since,
                                          input logic [16:0] lim);
        logic [31:0] diff;
        diff = now - since;
        if (now >= since) begin
            return diff >= {15'd0, lim};
        end
        return lim == 17'd0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_sp <= 14'sd2000;
            r_cool_sp <= 14'sd2400;
            r_hyst    <= 10'd50;
            r_sustain <= 17'd300;
            r_dwell   <= 17'd600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAT_SP: r_heat_sp <= i_cfg_data[13:0];
                CFG_COOL_SP: r_cool_sp <= i_cfg_data[13:0];
                CFG_HYST:    r_hyst    <= i_cfg_data[9:0];
                CFG_SUSTAIN: r_sustain <= i_cfg_data;
                CFG_DWELL:   r_dwell   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_st      <= '0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign t_ext       = 16'(r_in.temperature);
    assign heat_sp_ext = 16'(r_heat_sp);
    assign cool_sp_ext = 16'(r_cool_sp);
    assign heat_on     = heat_sp_ext - $signed({6'd0, r_hyst});
    assign cool_on     = cool_sp_ext + $signed({6'd0, r_hyst});
    assign heat_trig   = t_ext <= heat_on;
    assign cool_trig   = t_ext >= cool_on;

    always_comb begin
        n_st    = r_st;
        go_auto = 1'b0;
        if (r_in.user_mode != r_st.prev_mode) begin
            n_st            = f_end_call(n_st, r_in.now_seconds);
            n_st.heat_armed = 1'b0;
            n_st.cool_armed = 1'b0;
            n_st.prev_mode  = r_in.user_mode;
        end

        if (!r_in.sample_valid) begin
            n_st            = f_end_call(n_st, r_in.now_seconds);
            n_st.heat_armed = 1'b0;
            n_st.cool_armed = 1'b0;
        end else begin
            case (r_in.user_mode)
                MODE_HEAT, MODE_EHEAT: begin
                    if (n_st.kind == KIND_HEAT) begin
                        if (t_ext >= heat_sp_ext) begin
                            n_st = f_end_call(n_st, r_in.now_seconds);
                        end
                    end else if (n_st.kind == KIND_NONE && heat_trig) begin
                        n_st.kind = KIND_HEAT;
                        n_st.gas  = (r_in.user_mode == MODE_EHEAT);
                    end
                end
                MODE_COOL: begin
                    if (n_st.kind == KIND_COOL) begin
                        if (t_ext <= cool_sp_ext) begin
                            n_st = f_end_call(n_st, r_in.now_seconds);
                        end
                    end else if (n_st.kind == KIND_NONE && cool_trig) begin
                        n_st.kind = KIND_COOL;
                        n_st.gas  = 1'b0;
                    end
                end
                MODE_AUTO: begin
                    go_auto = 1'b1;
                    if (n_st.kind == KIND_HEAT) begin
                        if (t_ext >= heat_sp_ext) begin
                            n_st = f_end_call(n_st, r_in.now_seconds);
                        end else begin
                            go_auto = 1'b0;
                        end
                    end else if (n_st.kind == KIND_COOL) begin
                        if (t_ext <= cool_sp_ext) begin
                            n_st = f_end_call(n_st, r_in.now_seconds);
                        end else begin
                            go_auto = 1'b0;
                        end
                    end
                    if (go_auto) begin
                        if (heat_trig && !n_st.heat_armed) begin
                            n_st.heat_since = r_in.now_seconds;
                        end
                        n_st.heat_armed = heat_trig;
                        if (cool_trig && !n_st.cool_armed) begin
                            n_st.cool_since = r_in.now_seconds;
                        end
                        n_st.cool_armed = cool_trig;
                        if (heat_trig && !cool_trig) begin
                            if (n_st.last_kind != KIND_COOL ||
                                (f_elapsed_ge(r_in.now_seconds, n_st.heat_since, r_sustain) &&
                                 n_st.cool_ended &&
                                 f_elapsed_ge(r_in.now_seconds, n_st.cool_end_t, r_dwell) &&
                                 r_in.swap_allowed)) begin
                                n_st.kind = KIND_HEAT;
                                n_st.gas  = 1'b0;
                            end
                        end else if (cool_trig && !heat_trig) begin
                            if (n_st.last_kind != KIND_HEAT ||
                                (f_elapsed_ge(r_in.now_seconds, n_st.cool_since, r_sustain) &&
                                 n_st.heat_ended &&
                                 f_elapsed_ge(r_in.now_seconds, n_st.heat_end_t, r_dwell) &&
                                 r_in.swap_allowed)) begin
                                n_st.kind = KIND_COOL;
                                n_st.gas  = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    n_st            = f_end_call(n_st, r_in.now_seconds);
                    n_st.heat_armed = 1'b0;
                    n_st.cool_armed = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        err = '0;
        if (n_st.kind == KIND_HEAT) begin
            err = heat_sp_ext - t_ext;
        end else if (n_st.kind == KIND_COOL) begin
            err = t_ext - cool_sp_ext;
        end
        n_out.demand_kind  = n_st.kind;
        n_out.gas_only     = (n_st.kind == KIND_HEAT) && n_st.gas;
        n_out.demand_error = err[15] ? 14'd0 : err[13:0];
        n_out.sensor_fault = !r_in.sample_valid;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_gas_needs_heat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.gas_only |-> o_out_data.demand_kind == KIND_HEAT)
        else $error("gas-only mark without heating call");

    a_idle_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.demand_kind == KIND_NONE |-> o_out_data.demand_error == 14'd0)
        else $error("demand error without call");

    a_fault_no_call: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sensor_fault |-> o_out_data.demand_kind == KIND_NONE)
        else $error("call held through sensor fault");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("result lost on advance");

    a_heat_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.kind == KIND_HEAT |-> (r_st.prev_mode == MODE_HEAT ||
            r_st.prev_mode == MODE_AUTO || r_st.prev_mode == MODE_EHEAT))
        else $error("heating call in a mode without heat");

endmodule

### tb/tb_thermostat_call_demand_core.sv
// Self-checking testbench for the thermostat call demand core: directed and random samples.
module tb_thermostat_call_demand_core;
    import tcd_pkg::*;

    localparam int LIMIT = 400000;

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [2:0]            cfg_idx   = CFG_HEAT_SP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;

    thermostat_call_demand_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // configuration copy
    int          heat_sp;
    int          cool_sp;
    int          hyst;
    logic [31:0] sustain;
    logic [31:0] dwell;

    // call state copy
    logic [1:0]  call_kind;
    bit          call_gas;
    logic [2:0]  last_mode;
    bit          heat_armed;
    bit          cool_armed;
    logic [31:0] heat_since;
    logic [31:0] cool_since;
    bit          heat_done;
    bit          cool_done;
    logic [31:0] heat_end_t;
    logic [31:0] cool_end_t;
    logic [1:0]  last_kind;

    t_in  sample_q[$];
    t_out demand_q[$];
    t_out want;

    int sent_count    = 0;
    int checked_count = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int burst_left    = 8;
    int gap_left      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int pattern_left  = 0;
    int stall_pct     = 0;

    // sample generator state
    int          gen_temp;
    int          gen_dir;
    logic [31:0] gen_now;
    logic [2:0]  gen_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] since(logic [31:0] now, logic [31:0] then_t);
        return (now >= then_t) ? now - then_t : 32'd0;
    endfunction

    function automatic void close_call(logic [31:0] now);
        if (call_kind == KIND_HEAT) begin
            heat_done  = 1'b1;
            heat_end_t = now;
            last_kind  = KIND_HEAT;
        end else if (call_kind == KIND_COOL) begin
            cool_done  = 1'b1;
            cool_end_t = now;
            last_kind  = KIND_COOL;
        end
        call_kind = KIND_NONE;
        call_gas  = 1'b0;
    endfunction

    function automatic void disarm_triggers();
        heat_armed = 1'b0;
        cool_armed = 1'b0;
    endfunction

    function automatic void eval_single(logic [1:0] wanted, int t, logic [31:0] now, bit gas);
        bit heating;
        int sp;
        heating = (wanted == KIND_HEAT);
        sp = heating ? heat_sp : cool_sp;
        if (call_kind == wanted) begin
            if (heating ? (t >= sp) : (t <= sp))
                close_call(now);
        end else if (call_kind == KIND_NONE) begin
            if (heating ? (t <= sp - hyst) : (t >= sp + hyst)) begin
                call_kind = wanted;
                call_gas  = gas;
            end
        end
    endfunction

    function automatic void eval_auto(int t, logic [31:0] now, bit swap);
        bit heat_trig;
        bit cool_trig;
        if (call_kind == KIND_HEAT) begin
            if (t >= heat_sp)
                close_call(now);
            else
                return;
        end else if (call_kind == KIND_COOL) begin
            if (t <= cool_sp)
                close_call(now);
            else
                return;
        end
        heat_trig = (t <= heat_sp - hyst);
        cool_trig = (t >= cool_sp + hyst);
        if (heat_trig && !heat_armed) begin
            heat_armed = 1'b1;
            heat_since = now;
        end
        if (!heat_trig)
            heat_armed = 1'b0;
        if (cool_trig && !cool_armed) begin
            cool_armed = 1'b1;
            cool_since = now;
        end
        if (!cool_trig)
            cool_armed = 1'b0;
        if (heat_trig && cool_trig)
            return;
        if (heat_trig) begin
            if (last_kind != KIND_COOL ||
                (since(now, heat_since) >= sustain && cool_done &&
                 since(now, cool_end_t) >= dwell && swap)) begin
                call_kind = KIND_HEAT;
                call_gas  = 1'b0;
            end
        end else if (cool_trig) begin
            if (last_kind != KIND_HEAT ||
                (since(now, cool_since) >= sustain && heat_done &&
                 since(now, heat_end_t) >= dwell && swap)) begin
                call_kind = KIND_COOL;
                call_gas  = 1'b0;
            end
        end
    endfunction

    function automatic t_out predict_demand(t_in s);
        int   t;
        int   err;
        t_out r;
        t   = $signed(s.temperature);
        err = 0;
        if (s.user_mode != last_mode) begin
            close_call(s.now_seconds);
            disarm_triggers();
            last_mode = s.user_mode;
        end
        if (!s.sample_valid) begin
            close_call(s.now_seconds);
            disarm_triggers();
        end else begin
            case (s.user_mode)
                MODE_HEAT:  eval_single(KIND_HEAT, t, s.now_seconds, 1'b0);
                MODE_COOL:  eval_single(KIND_COOL, t, s.now_seconds, 1'b0);
                MODE_AUTO:  eval_auto(t, s.now_seconds, s.swap_allowed);
                MODE_EHEAT: eval_single(KIND_HEAT, t, s.now_seconds, 1'b1);
                default: begin
                    close_call(s.now_seconds);
                    disarm_triggers();
                end
            endcase
        end
        if (call_kind == KIND_HEAT)
            err = heat_sp - t;
        else if (call_kind == KIND_COOL)
            err = t - cool_sp;
        if (err < 0)
            err = 0;
        if (err > 16383)
            err = 16383;
        r.demand_kind  = call_kind;
        r.gas_only     = (call_kind == KIND_HEAT) && call_gas;
        r.demand_error = err[13:0];
        r.sensor_fault = !s.sample_valid;
        return r;
    endfunction

    function automatic void reset_model();
        heat_sp    = 2000;
        cool_sp    = 2400;
        hyst       = 50;
        sustain    = 32'd300;
        dwell      = 32'd600;
        call_kind  = KIND_NONE;
        call_gas   = 1'b0;
        last_mode  = MODE_OFF;
        heat_armed = 1'b0;
        cool_armed = 1'b0;
        heat_since = '0;
        cool_since = '0;
        heat_done  = 1'b0;
        cool_done  = 1'b0;
        heat_end_t = '0;
        cool_end_t = '0;
        last_kind  = KIND_NONE;
    endfunction

    function automatic t_in next_sample();
        int  r;
        int  lo;
        int  hi;
        t_in s;
        lo = ((heat_sp < cool_sp) ? heat_sp : cool_sp) - hyst - 100;
        hi = ((heat_sp > cool_sp) ? heat_sp : cool_sp) + hyst + 100;
        if ($urandom_range(0, 39) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 45)      gen_mode = MODE_AUTO;
            else if (r < 57) gen_mode = MODE_HEAT;
            else if (r < 69) gen_mode = MODE_COOL;
            else if (r < 81) gen_mode = MODE_EHEAT;
            else if (r < 91) gen_mode = MODE_OFF;
            else             gen_mode = 3'($urandom_range(5, 7));
        end
        r = $urandom_range(0, 99);
        if (r < 2)       gen_now = $urandom;
        else if (r < 5)  gen_now = gen_now - $urandom_range(1, 50);
        else if (r < 15) gen_now = gen_now + $urandom_range(50, 400);
        else             gen_now = gen_now + $urandom_range(0, 20);
        if ($urandom_range(0, 19) == 0)
            gen_dir = -gen_dir;
        gen_temp = gen_temp + gen_dir * $urandom_range(0, (hi - lo) / 6 + 3);
        if (gen_temp > hi) gen_dir = -1;
        if (gen_temp < lo) gen_dir = 1;
        if (gen_temp > 8191)  gen_temp = 8191;
        if (gen_temp < -8192) gen_temp = -8192;
        s.temperature  = ($urandom_range(0, 49) == 0) ? 14'($urandom) : 14'(gen_temp);
        s.sample_valid = ($urandom_range(0, 99) >= 5);
        s.now_seconds  = gen_now;
        s.swap_allowed = ($urandom_range(0, 99) >= 20);
        s.user_mode    = gen_mode;
        return s;
    endfunction

    task automatic add_sample(int t, bit v, logic [31:0] now, bit swap, logic [2:0] mode);
        t_in s;
        s.temperature  = 14'(t);
        s.sample_valid = v;
        s.now_seconds  = now;
        s.swap_allowed = swap;
        s.user_mode    = mode;
        sample_q.push_back(s);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_HEAT_SP: heat_sp = $signed(data[13:0]);
            CFG_COOL_SP: cool_sp = $signed(data[13:0]);
            CFG_HYST:    hyst    = int'(data[9:0]);
            CFG_SUSTAIN: sustain = 32'(data[16:0]);
            CFG_DWELL:   dwell   = 32'(data[16:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || sent_count != checked_count)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int hs, int cs, int hy, int su, int dw, int n);
        write_reg(CFG_HEAT_SP, 17'(hs));
        write_reg(CFG_COOL_SP, 17'(cs));
        write_reg(CFG_HYST, 17'(hy));
        write_reg(CFG_SUSTAIN, 17'(su));
        write_reg(CFG_DWELL, 17'(dw));
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        gen_temp = heat_sp;
        gen_dir  = 1;
        @(posedge i_clk);
        repeat (n)
            sample_q.push_back(next_sample());
        drain();
    endtask

    task automatic report(string what, int got, int exp_val);
        if (fail_count < 40)
            $display("MISMATCH %s: got %0d expected %0d", what, got, exp_val);
        fail_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid)
                demand_q.push_back(predict_demand(in_data));
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                in_data  <= sample_q.pop_front();
                in_valid <= 1'b1;
                sent_count++;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 50);
                    gap_left   = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (demand_q.size() == 0) begin
                    report("unexpected result", out_data.demand_kind, 0);
                end else begin
                    want = demand_q.pop_front();
                    checked_count++;
                    if (out_data.demand_kind != want.demand_kind)
                        report("demand_kind", out_data.demand_kind, want.demand_kind);
                    if (out_data.gas_only != want.gas_only)
                        report("gas_only", out_data.gas_only, want.gas_only);
                    if (out_data.demand_error != want.demand_error)
                        report("demand_error", out_data.demand_error, want.demand_error);
                    if (out_data.sensor_fault != want.sensor_fault)
                        report("sensor_fault", out_data.sensor_fault, want.sensor_fault);
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && checked_count >= 900) begin
                hold_done = 1'b1;
                hold_left = 400;
                out_stall <= 1'b1;
            end else begin
                if (pattern_left <= 0) begin
                    case ($urandom_range(0, 3))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                    pattern_left = $urandom_range(8, 80);
                end
                pattern_left = pattern_left - 1;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        reset_model();
        gen_temp = 2000;
        gen_dir  = 1;
        gen_now  = '0;
        gen_mode = MODE_AUTO;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        add_sample(2100, 1, 0, 1, MODE_HEAT);
        add_sample(1950, 1, 10, 1, MODE_HEAT);
        add_sample(1999, 1, 20, 1, MODE_HEAT);
        add_sample(2000, 1, 30, 1, MODE_HEAT);
        add_sample(1900, 1, 40, 0, MODE_EHEAT);
        add_sample(1900, 0, 50, 0, MODE_EHEAT);
        add_sample(2450, 1, 60, 1, MODE_COOL);
        add_sample(2400, 1, 70, 1, MODE_COOL);
        add_sample(2450, 1, 80, 1, 3'd5);
        add_sample(1000, 1, 90, 1, MODE_OFF);
        add_sample(1900, 1, 100, 1, MODE_AUTO);
        add_sample(1900, 1, 500, 1, MODE_AUTO);
        add_sample(1900, 1, 700, 0, MODE_AUTO);
        add_sample(1900, 1, 710, 1, MODE_AUTO);
        add_sample(2000, 1, 720, 1, MODE_AUTO);
        add_sample(2450, 1, 730, 1, MODE_AUTO);
        add_sample(2450, 1, 600, 1, MODE_AUTO);
        add_sample(2450, 1, 1400, 1, MODE_AUTO);
        add_sample(8000, 1, 1410, 1, MODE_AUTO);
        add_sample(-4000, 1, 1420, 1, MODE_AUTO);
        add_sample(-8192, 1, 32'hFFFF_FFFF, 1, MODE_EHEAT);
        add_sample(8191, 1, 32'hFFFF_FFFF, 1, MODE_EHEAT);
        add_sample(8191, 1, 0, 1, MODE_COOL);
        add_sample(-8192, 0, 0, 0, 3'd7);
        drain();

        run_phase(2000, 2400, 50, 30, 60, 350);
        run_phase(-4000, 8000, 1000, 0, 0, 350);
        run_phase(8000, -4000, 0, 86400, 86400, 350);
        run_phase(2100, 2150, 20, 5, 10, 350);
        begin
            int hs;
            hs = $urandom_range(0, 12000) - 4000;
            run_phase(hs, hs + $urandom_range(0, 8000 - hs), $urandom_range(0, 1000),
                      $urandom_range(0, 200), $urandom_range(0, 200), 350);
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
